@@ rtl/assert_macros.svh @@
// Assertion helpers for the character LCD writer.
// Both expect clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CLNW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLNW_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CLNW_ASSERT(lbl, prop, msg)
`define CLNW_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/clnw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, codes and init tables of the 4-bit character LCD writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_COMMAND   = 2'd3;

    localparam logic [15:0] PULSE_RESET    = 16'd25;
    localparam logic [15:0] BYTE_GAP_RESET = 16'd1000;
    localparam logic [5:0]  LINE_LEN_RESET = 6'd16;
    localparam logic [7:0]  WRAP_RESET     = 8'hC0;

    localparam logic [1:0] CMD_COMMAND = 2'd0;
    localparam logic [1:0] CMD_DATA    = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;
    localparam logic [1:0] CMD_TEXT    = 2'd3;

    localparam logic JOB_BYTE = 1'b0;
    localparam logic JOB_INIT = 1'b1;

    localparam logic [5:0]  COUNT_MAX       = 6'd63;
    localparam logic [16:0] INIT_IDLE_TICKS = 17'd3200;
    localparam logic [2:0]  INIT_LAST_SEG   = 3'd6;

    // Phase codes within one byte
    localparam logic [1:0] PH_HI_HIGH = 2'd0;
    localparam logic [1:0] PH_HI_LOW  = 2'd1;
    localparam logic [1:0] PH_LO_HIGH = 2'd2;
    localparam logic [1:0] PH_LO_LOW  = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [15:0] byte_gap_ticks;
        logic [7:0]  wrap_command;
    } clnw_cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       rs;
        logic       wrap;
    } clnw_job_t;

    // Init segment 1..6 carries the fixed command bytes
    function automatic logic [7:0] init_byte(input logic [2:0] seg);
        logic [7:0] b;
        case (seg)
            3'd1:    b = 8'h33;
            3'd2:    b = 8'h32;
            3'd3:    b = 8'h28;
            3'd4:    b = 8'h0C;
            3'd5:    b = 8'h06;
            3'd6:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [14:0] init_extra(input logic [2:0] seg);
        logic [14:0] e;
        case (seg)
            3'd1, 3'd2, 3'd3: e = 15'd30000;
            3'd4, 3'd5:       e = 15'd800;
            3'd6:             e = 15'd10000;
            default:          e = 15'd0;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/clnw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_in_if / clnw_out_if
// Valid/ready channels for request beats and pin phase beats.
// ----------------------------------------------------------------------------
interface clnw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       text_first;

    modport source (output valid, output command, output byte_value, output text_first,
                    input ready);
    modport sink   (input valid, input command, input byte_value, input text_first,
                    output ready);
endinterface

interface clnw_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  data_nibble;
    logic        register_select;
    logic        enable_level;
    logic [16:0] hold_ticks;
    logic        last;

    modport source (output valid, output data_nibble, output register_select,
                    output enable_level, output hold_ticks, output last, input ready);
    modport sink   (input valid, input data_nibble, input register_select,
                    input enable_level, input hold_ticks, input last, output ready);
endinterface

@@ rtl/clnw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_front
// Accepts requests, keeps the config registers and the text character count,
// and turns each request into one job for the queue.
// ----------------------------------------------------------------------------
module clnw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    clnw_in_if.sink                        cmd_ch,
    input  logic                           cfg_we,
    input  logic [clnw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           q_full,
    output logic                           q_push,
    output clnw_pkg::clnw_job_t            q_job,
    output clnw_pkg::clnw_cfg_t            cfg
);
    import clnw_pkg::*;

    logic [15:0] pulse_reg;
    logic [15:0] gap_reg;
    logic [5:0]  line_len_reg;
    logic [7:0]  wrap_reg;
    logic [5:0]  count_reg;
    logic [5:0]  count_next;
    logic [5:0]  count_base;
    logic [5:0]  count_inc;
    logic        count_sat;

    assign cmd_ch.ready = !q_full;
    assign q_push       = cmd_ch.valid && !q_full;

    assign cfg.pulse_ticks    = pulse_reg;
    assign cfg.byte_gap_ticks = gap_reg;
    assign cfg.wrap_command   = wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg    <= PULSE_RESET;
            gap_reg      <= BYTE_GAP_RESET;
            line_len_reg <= LINE_LEN_RESET;
            wrap_reg     <= WRAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE_TICKS:    pulse_reg    <= cfg_wdata;
                REG_BYTE_GAP_TICKS: gap_reg      <= cfg_wdata;
                REG_LINE_LENGTH:    line_len_reg <= cfg_wdata[5:0];
                REG_WRAP_COMMAND:   wrap_reg     <= cfg_wdata[7:0];
                default:            ;
            endcase
        end
    end

    // A string start clears the count before this character
    assign count_base = cmd_ch.text_first ? 6'd0 : count_reg;
    assign count_sat  = (count_base == COUNT_MAX);
    assign count_inc  = count_base + 6'd1;

    always_comb
    begin
        q_job.kind  = JOB_BYTE;
        q_job.value = cmd_ch.byte_value;
        q_job.rs    = 1'b0;
        q_job.wrap  = 1'b0;
        count_next  = count_reg;
        case (cmd_ch.command)
            CMD_COMMAND: q_job.rs = 1'b0;
            CMD_DATA:    q_job.rs = 1'b1;
            CMD_INIT:    q_job.kind = JOB_INIT;
            CMD_TEXT:
            begin
                q_job.rs   = 1'b1;
                q_job.wrap = !count_sat && (count_inc == line_len_reg);
                count_next = count_sat ? count_base : count_inc;
            end
            default:     q_job.kind = JOB_BYTE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 6'd0;
        else if (q_push)
            count_reg <= count_next;
    end

endmodule

@@ rtl/clnw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_queue
// Short job FIFO between the request front and the phase sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clnw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clnw_pkg::clnw_job_t push_job,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output clnw_pkg::clnw_job_t head
);
    import clnw_pkg::*;

    clnw_job_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `CLNW_NEVER(a_q_overfill, count_reg > QCNT_W'(QDEPTH), "job queue count above depth")
    `CLNW_NEVER(a_q_pop_empty, pop && !not_empty, "job popped from empty queue")
    `CLNW_ASSERT(a_q_grow, (push && !pop) |=> count_reg == $past(count_reg) + 1'b1, "count stuck")
endmodule

@@ rtl/clnw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_back
// Phase sequencer: expands the head job into pin phases, one per cycle while
// pin_ch is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module clnw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  clnw_pkg::clnw_job_t job,
    input  clnw_pkg::clnw_cfg_t cfg,
    output logic                job_pop,
    clnw_out_if.source          pin_ch
);
    import clnw_pkg::*;

    logic [1:0]  phase_reg;
    logic [2:0]  seg_reg;
    logic        out_valid_reg;
    logic [3:0]  nib_reg;
    logic        rs_reg;
    logic        en_reg;
    logic [16:0] hold_reg;
    logic        last_reg;

    logic        is_init;
    logic        idle_seg;
    logic [7:0]  cur_byte;
    logic [14:0] extra;
    logic        cur_rs;
    logic [3:0]  nib;
    logic        en;
    logic [16:0] hold;
    logic        seg_end;
    logic        is_last;
    logic        load;

    always_comb
    begin
        is_init  = (job.kind == JOB_INIT);
        idle_seg = is_init && (seg_reg == 3'd0);
        extra    = 15'd0;
        if (is_init)
        begin
            cur_byte = init_byte(seg_reg);
            extra    = init_extra(seg_reg);
            cur_rs   = 1'b0;
        end
        else if (seg_reg == 3'd0)
        begin
            cur_byte = job.value;
            cur_rs   = job.rs;
        end
        else
        begin
            cur_byte = cfg.wrap_command;
            cur_rs   = 1'b0;
        end

        nib = phase_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
        en  = !phase_reg[0];
        case (phase_reg)
            PH_HI_HIGH, PH_LO_HIGH: hold = {1'b0, cfg.pulse_ticks};
            PH_HI_LOW:              hold = 17'd0;
            PH_LO_LOW:              hold = {1'b0, cfg.byte_gap_ticks} + {2'b00, extra};
            default:                hold = 17'd0;
        endcase
        if (idle_seg)
        begin
            nib  = 4'd0;
            en   = 1'b0;
            hold = INIT_IDLE_TICKS;
        end

        seg_end = idle_seg || (phase_reg == PH_LO_LOW);
        if (is_init)
            is_last = (seg_reg == INIT_LAST_SEG) && (phase_reg == PH_LO_LOW);
        else
            is_last = (phase_reg == PH_LO_LOW) && ((seg_reg != 3'd0) || !job.wrap);
    end

    assign load    = job_valid && (!out_valid_reg || pin_ch.ready);
    assign job_pop = load && is_last;

    // Advance through the phases of the head job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HI_HIGH;
            seg_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    phase_reg <= PH_HI_HIGH;
                    seg_reg   <= 3'd0;
                end
                else if (seg_end)
                begin
                    phase_reg <= PH_HI_HIGH;
                    seg_reg   <= seg_reg + 3'd1;
                end
                else
                    phase_reg <= phase_reg + 2'd1;
            end
            else if (pin_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nib_reg  <= nib;
            rs_reg   <= cur_rs;
            en_reg   <= en;
            hold_reg <= hold;
            last_reg <= is_last;
        end
    end

    assign pin_ch.valid           = out_valid_reg;
    assign pin_ch.data_nibble     = nib_reg;
    assign pin_ch.register_select = rs_reg;
    assign pin_ch.enable_level    = en_reg;
    assign pin_ch.hold_ticks      = hold_reg;
    assign pin_ch.last            = last_reg;

endmodule

@@ rtl/char_lcd_nibble_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit character LCD writer: requests in, pin phases (nibble, RS, EN, hold)
// out.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// cmd_ch    in   command, byte_value, text_first
// pin_ch    out  data_nibble, register_select, enable_level, hold_ticks, last
// cfg_*     in   write enable, register index, 16-bit data
//
// One phase leaves per cycle from the sequencer unless pin_ch is stalled:
// a command or data byte is 4 phases, a text character 4 or 8 with the
// line wrap, init 25. Requests enter a 4-deep job queue, so the front takes
// new beats while the sequencer works and while pin_ch is stalled, until four
// jobs wait. Reset restores register defaults and clears the character count.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    clnw_in_if.sink                         cmd_ch,
    clnw_out_if.source                      pin_ch,
    input  logic                            cfg_we,
    input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import clnw_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;
    clnw_job_t push_job;
    clnw_job_t head_job;
    clnw_cfg_t cfg;

    clnw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .cfg       (cfg)
    );

    clnw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    clnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .cfg       (cfg),
        .job_pop   (q_pop),
        .pin_ch    (pin_ch)
    );

endmodule
